[src/crs_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// crs_pkg: shared types and constants of the closed Catmull-Rom evaluator
// Field layout, command format, datapath widths and the segment table.
// ----------------------------------------------------------------------------
package crs_pkg;

  // Table and number formats
  localparam int MAX_POINTS = 16;
  localparam int IDX_W      = $clog2(MAX_POINTS);
  localparam int COORD_W    = 16;
  localparam int FRAC_BITS  = 12;
  localparam int PARAM_W    = 16;
  localparam int INT_W      = PARAM_W - FRAC_BITS;
  localparam int PIDX_W     = 4;
  localparam int ACT_W      = 2;
  localparam int OUT_W      = 24;

  // Point count register
  localparam int                CNT_W     = 5;
  localparam logic [CNT_W-1:0]  CNT_RESET = CNT_W'(MAX_POINTS);
  localparam logic [CNT_W-1:0]  CNT_MIN   = CNT_W'(2);
  localparam logic [CNT_W-1:0]  CNT_MAX   = CNT_W'(MAX_POINTS);

  // Sums over neighbor indices
  localparam int NB_W = IDX_W + 2;

  // Stream layout of the input item
  localparam int TD_X_LSB   = PIDX_W;
  localparam int TD_Y_LSB   = TD_X_LSB + COORD_W;
  localparam int TD_T_LSB   = TD_Y_LSB + COORD_W;
  localparam int TD_USED    = TD_T_LSB + PARAM_W;
  localparam int S_TDATA_W  = ((TD_USED + 7) / 8) * 8;
  localparam int S_TUSER_W  = ACT_W;
  localparam int M_TDATA_W  = 2 * OUT_W;
  localparam int M_TUSER_W  = 1;

  // Datapath widths: coefficients, then one Horner step per stage
  localparam int COEF_W     = COORD_W + 5;
  localparam int ACC1_W     = COEF_W + FRAC_BITS + 1;
  localparam int ACC2_W     = ACC1_W + FRAC_BITS + 1;
  localparam int ACC3_W     = ACC2_W + FRAC_BITS + 1;
  localparam int RND_SHIFT  = 3 * FRAC_BITS + 1;
  localparam logic signed [ACC3_W-1:0] RND_HALF = ACC3_W'(1) <<< (3 * FRAC_BITS);

  // Command queue
  localparam int FIFO_DEPTH = 4;
  localparam int FIFO_AW    = $clog2(FIFO_DEPTH);

  typedef enum logic [ACT_W-1:0] {
    ACT_WRITE = 2'd0,
    ACT_POS   = 2'd1,
    ACT_GRAD  = 2'd2,
    ACT_NONE  = 2'd3
  } action_e;

  typedef logic [IDX_W-1:0] idx_t;

  // One classified item as it travels from the front to the back end
  typedef struct packed {
    action_e              kind;
    idx_t                 slot;
    logic [COORD_W-1:0]   px;
    logic [COORD_W-1:0]   py;
    idx_t [3:0]           nbr;
    logic [FRAC_BITS-1:0] frac;
  } cmd_t;

  // Segment table: index {count - 1, integer part of t} -> integer part mod count
  localparam int SEG_ROWS = 2 ** INT_W;
  localparam int SEG_LUT_DEPTH = MAX_POINTS * SEG_ROWS;
  typedef logic [SEG_LUT_DEPTH-1:0][IDX_W-1:0] seg_lut_t;

  function automatic seg_lut_t build_seg_lut();
    seg_lut_t lut;
    int       r;
    lut = '0;
    for (int n = 1; n <= MAX_POINTS; n++) begin
      for (int i = 0; i < SEG_ROWS; i++) begin
        r = i;
        for (int k = 0; k < SEG_ROWS; k++) begin
          if (r >= n) begin
            r = r - n;
          end
        end
        lut[(n - 1) * SEG_ROWS + i] = IDX_W'(r);
      end
    end
    return lut;
  endfunction

  localparam seg_lut_t SEG_LUT = build_seg_lut();

endpackage

[src/crs_ram.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// crs_ram: generic RAM, one write port and two registered read ports
// Read data updates only when the read enable is high.
// ----------------------------------------------------------------------------
module crs_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_a_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_b_i,
  output logic [WIDTH-1:0]         rdata_a_o,
  output logic [WIDTH-1:0]         rdata_b_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_a_q;
  logic [WIDTH-1:0] rdata_b_q;

  // Write and read, old data on a same-address collision
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_a_q <= mem_q[raddr_a_i];
      rdata_b_q <= mem_q[raddr_b_i];
    end
  end

  assign rdata_a_o = rdata_a_q;
  assign rdata_b_o = rdata_b_q;

endmodule

[src/crs_fifo.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// crs_fifo: command queue between the front and the back end
// Small register FIFO with ready/valid on both sides.
// ----------------------------------------------------------------------------
module crs_fifo import crs_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic push_valid_i,
  output logic push_ready_o,
  input  cmd_t push_cmd_i,
  output logic pop_valid_o,
  input  logic pop_ready_i,
  output cmd_t pop_cmd_o
);

  cmd_t               mem_q [FIFO_DEPTH];
  logic [FIFO_AW:0]   wr_ptr_q, wr_ptr_d;
  logic [FIFO_AW:0]   rd_ptr_q, rd_ptr_d;
  logic               full;
  logic               empty;
  logic               push;
  logic               pop;

  assign empty = (wr_ptr_q == rd_ptr_q);
  assign full  = (wr_ptr_q[FIFO_AW] != rd_ptr_q[FIFO_AW]) &&
                 (wr_ptr_q[FIFO_AW-1:0] == rd_ptr_q[FIFO_AW-1:0]);

  assign push_ready_o = !full;
  assign pop_valid_o  = !empty;
  assign push = push_valid_i && !full;
  assign pop  = pop_ready_i && !empty;

  assign pop_cmd_o = mem_q[rd_ptr_q[FIFO_AW-1:0]];

  // Advance pointers on each transfer
  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    if (push) begin
      wr_ptr_d = wr_ptr_q + 1'b1;
    end
    if (pop) begin
      rd_ptr_d = rd_ptr_q + 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
    end
  end

  // Store the entry
  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_ptr_q[FIFO_AW-1:0]] <= push_cmd_i;
    end
  end

endmodule

[src/crs_front.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// crs_front: input side of the spline evaluator
// Holds the point count, classifies items and works out the four table
// indices around the selected segment, wrapping round the loop.
// ----------------------------------------------------------------------------
module crs_front import crs_pkg::*; (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 s_axis_tvalid_i,
  output logic                 s_axis_tready_o,
  input  logic [S_TDATA_W-1:0] s_axis_tdata_i,
  input  logic [S_TUSER_W-1:0] s_axis_tuser_i,
  input  logic                 cfg_valid_i,
  output logic                 cfg_ready_o,
  input  logic [CNT_W-1:0]     cfg_data_i,
  output logic                 cmd_valid_o,
  input  logic                 cmd_ready_i,
  output cmd_t                 cmd_o
);

  logic [CNT_W-1:0]   cnt_q, cnt_d;
  logic [CNT_W-1:0]   n_eff;
  idx_t               n_m1;
  logic [NB_W-1:0]    n_ext;
  logic [INT_W-1:0]   int_part;
  idx_t               seg;
  logic [NB_W-1:0]    seg_p1;
  logic [NB_W-1:0]    seg_p2;
  logic [PIDX_W-1:0]  pidx;

  // Point count register, always ready
  assign cfg_ready_o = 1'b1;

  always_comb begin
    cnt_d = cnt_q;
    if (cfg_valid_i) begin
      cnt_d = cfg_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= CNT_RESET;
    end else begin
      cnt_q <= cnt_d;
    end
  end

  // Clamp the count to the table
  always_comb begin
    if (cnt_q < CNT_MIN) begin
      n_eff = CNT_MIN;
    end else if (cnt_q > CNT_MAX) begin
      n_eff = CNT_MAX;
    end else begin
      n_eff = cnt_q;
    end
  end

  assign n_m1  = IDX_W'(n_eff - CNT_W'(1));
  assign n_ext = NB_W'(n_eff);

  // Segment from the integer part of t, then its neighbors
  assign int_part = s_axis_tdata_i[TD_T_LSB + FRAC_BITS +: INT_W];
  assign seg      = SEG_LUT[{n_m1, int_part}];
  assign seg_p1   = NB_W'(seg) + NB_W'(1);
  assign seg_p2   = NB_W'(seg) + NB_W'(2);
  assign pidx     = s_axis_tdata_i[PIDX_W-1:0];

  always_comb begin
    cmd_o.kind   = action_e'(s_axis_tuser_i);
    cmd_o.slot   = IDX_W'(pidx);
    cmd_o.px     = s_axis_tdata_i[TD_X_LSB +: COORD_W];
    cmd_o.py     = s_axis_tdata_i[TD_Y_LSB +: COORD_W];
    cmd_o.frac   = s_axis_tdata_i[TD_T_LSB +: FRAC_BITS];
    cmd_o.nbr[1] = seg;
    cmd_o.nbr[0] = (seg == '0) ? n_m1 : seg - IDX_W'(1);
    cmd_o.nbr[2] = (seg_p1 == n_ext) ? '0 : seg_p1[IDX_W-1:0];
    cmd_o.nbr[3] = (seg_p2 >= n_ext) ? IDX_W'(seg_p2 - n_ext) : seg_p2[IDX_W-1:0];
  end

  // Hand the item to the queue
  assign cmd_valid_o     = s_axis_tvalid_i;
  assign s_axis_tready_o = cmd_ready_i;

endmodule

[src/crs_back.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// crs_back: point table and blending pipeline
// Stores points, reads the four neighbors, forms the cubic coefficients and
// evaluates the polynomial by Horner's rule, one multiply per stage, then
// rounds into the output register. All stages advance together.
// ----------------------------------------------------------------------------
module crs_back import crs_pkg::*; (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cmd_valid_i,
  output logic                 cmd_ready_o,
  input  cmd_t                 cmd_i,
  output logic                 m_axis_tvalid_o,
  input  logic                 m_axis_tready_i,
  output logic [M_TDATA_W-1:0] m_axis_tdata_o,
  output logic [M_TUSER_W-1:0] m_axis_tuser_o
);

  localparam int PAIR_W = 2 * COORD_W;

  logic                  adv;
  logic                  wr_en;
  logic [PAIR_W-1:0]     rd0a, rd0b, rd1a, rd1b;

  // Stage valid bits and sideband
  logic                  v1_q, v2_q, v3_q, v4_q, v5_q;
  action_e               kind1_q, kind2_q, kind3_q, kind4_q, kind5_q;
  logic [FRAC_BITS-1:0]  frac1_q, frac2_q, frac3_q, frac4_q;
  logic signed [FRAC_BITS:0] fs2, fs3, fs4;
  logic                  grad1, grad4;

  logic signed [OUT_W-1:0] lane_res [2];

  logic                  out_valid_q;
  logic [M_TDATA_W-1:0]  out_data_q, out_data_d;
  logic [M_TUSER_W-1:0]  out_user_q, out_user_d;

  // Whole pipeline moves when the output register is free
  assign adv         = !out_valid_q || m_axis_tready_i;
  assign cmd_ready_o = adv;
  assign wr_en       = adv && cmd_valid_i && (cmd_i.kind == ACT_WRITE);

  // Point table, two copies for four reads per cycle
  crs_ram #(.WIDTH(PAIR_W), .DEPTH(MAX_POINTS)) u_ram0 (
    .clk_i     (clk_i),
    .we_i      (wr_en),
    .waddr_i   (cmd_i.slot),
    .wdata_i   ({cmd_i.py, cmd_i.px}),
    .re_i      (adv),
    .raddr_a_i (cmd_i.nbr[0]),
    .raddr_b_i (cmd_i.nbr[1]),
    .rdata_a_o (rd0a),
    .rdata_b_o (rd0b)
  );

  crs_ram #(.WIDTH(PAIR_W), .DEPTH(MAX_POINTS)) u_ram1 (
    .clk_i     (clk_i),
    .we_i      (wr_en),
    .waddr_i   (cmd_i.slot),
    .wdata_i   ({cmd_i.py, cmd_i.px}),
    .re_i      (adv),
    .raddr_a_i (cmd_i.nbr[2]),
    .raddr_b_i (cmd_i.nbr[3]),
    .rdata_a_o (rd1a),
    .rdata_b_o (rd1b)
  );

  // Valid bits
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q        <= 1'b0;
      v2_q        <= 1'b0;
      v3_q        <= 1'b0;
      v4_q        <= 1'b0;
      v5_q        <= 1'b0;
      out_valid_q <= 1'b0;
    end else if (adv) begin
      v1_q        <= cmd_valid_i;
      v2_q        <= v1_q;
      v3_q        <= v2_q;
      v4_q        <= v3_q;
      v5_q        <= v4_q;
      out_valid_q <= v5_q;
    end
  end

  // Sideband along the stages
  always_ff @(posedge clk_i) begin
    if (adv) begin
      kind1_q <= cmd_i.kind;
      kind2_q <= kind1_q;
      kind3_q <= kind2_q;
      kind4_q <= kind3_q;
      kind5_q <= kind4_q;
      frac1_q <= cmd_i.frac;
      frac2_q <= frac1_q;
      frac3_q <= frac2_q;
      frac4_q <= frac3_q;
    end
  end

  assign grad1 = (kind1_q == ACT_GRAD);
  assign grad4 = (kind4_q == ACT_GRAD);
  assign fs2   = $signed({1'b0, frac2_q});
  assign fs3   = $signed({1'b0, frac3_q});
  assign fs4   = $signed({1'b0, frac4_q});

  // One lane per coordinate
  for (genvar g = 0; g < 2; g++) begin : g_lane
    logic signed [COORD_W-1:0] p0, p1, p2, p3;
    logic signed [COEF_W-1:0]  e0, e1, e2, e3;
    logic signed [COEF_W-1:0]  ca, cb;
    logic signed [COEF_W-1:0]  a2_q, b2_q, c2_q, d2_q;
    logic signed [COEF_W-1:0]  c3_q, d3_q, d4_q;
    logic signed [ACC1_W-1:0]  prod1, acc1_q;
    logic signed [ACC2_W-1:0]  prod2, acc2_q;
    logic signed [ACC3_W-1:0]  prod3, acc3_q;
    logic signed [ACC3_W-1:0]  rnd, shr;

    assign p0 = $signed(rd0a[g*COORD_W +: COORD_W]);
    assign p1 = $signed(rd0b[g*COORD_W +: COORD_W]);
    assign p2 = $signed(rd1a[g*COORD_W +: COORD_W]);
    assign p3 = $signed(rd1b[g*COORD_W +: COORD_W]);
    assign e0 = COEF_W'(p0);
    assign e1 = COEF_W'(p1);
    assign e2 = COEF_W'(p2);
    assign e3 = COEF_W'(p3);

    // Cubic coefficients a and b of the uniform basis
    assign ca = (e3 - e0) + ((e1 <<< 1) + e1) - ((e2 <<< 1) + e2);
    assign cb = (e0 <<< 1) - ((e1 <<< 2) + e1) + (e2 <<< 2) - e3;

    // Horner products, one multiplier per stage
    assign prod1 = a2_q * fs2;
    assign prod2 = acc1_q * fs3;
    assign prod3 = acc2_q * fs4;

    always_ff @(posedge clk_i) begin
      if (adv) begin
        // Coefficients, pre-scaled for the derivative
        a2_q   <= grad1 ? (ca <<< 1) + ca : ca;
        b2_q   <= grad1 ? (cb <<< 1) : cb;
        c2_q   <= e2 - e0;
        d2_q   <= e1 <<< 1;
        // a f + b S
        acc1_q <= prod1 + (ACC1_W'(b2_q) <<< FRAC_BITS);
        c3_q   <= c2_q;
        d3_q   <= d2_q;
        // ... f + c S^2
        acc2_q <= prod2 + (ACC2_W'(c3_q) <<< (2 * FRAC_BITS));
        d4_q   <= d3_q;
        // ... f + d S^3, or align the derivative to the same scale
        acc3_q <= grad4 ? (ACC3_W'(acc2_q) <<< FRAC_BITS)
                        : prod3 + (ACC3_W'(d4_q) <<< (3 * FRAC_BITS));
      end
    end

    // Round half up and drop to Q20.4
    assign rnd = acc3_q + RND_HALF;
    assign shr = rnd >>> RND_SHIFT;
    assign lane_res[g] = shr[OUT_W-1:0];
  end

  // Result select: blend for evaluations, zero otherwise, write_ack set for writes
  always_comb begin
    out_data_d = '0;
    out_user_d = '0;
    case (kind5_q)
      ACT_POS, ACT_GRAD: begin
        out_data_d = {lane_res[1], lane_res[0]};
      end
      ACT_WRITE: begin
        out_user_d = M_TUSER_W'(1);
      end
      default: begin
        out_data_d = '0;
      end
    endcase
  end

  // Output register
  always_ff @(posedge clk_i) begin
    if (adv) begin
      out_data_q <= out_data_d;
      out_user_q <= out_user_d;
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = out_data_q;
  assign m_axis_tuser_o  = out_user_q;

endmodule

[src/catmull_rom_closed_spline_eval.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// catmull_rom_closed_spline_eval: closed-loop Catmull-Rom curve evaluator
// Stores up to 16 signed Q12.4 points and evaluates position or tangent.
// ----------------------------------------------------------------------------
// Usage:
//   s_axis carries one item per transfer. tuser is the action (write point,
//   evaluate position, evaluate tangent). tdata holds point_index, point_x,
//   point_y and param_t (Q4.12). Every item gives exactly one m_axis result:
//   tdata holds out_x and out_y (Q20.4), tuser is write_ack.
//   The cfg channel writes the point count; it is always ready and is to be
//   written only while no item is in flight.
// Timing:
//   One item per cycle is sustained while the output is not stalled: the
//   front end, a 4-entry queue and the six-stage back end (table read,
//   coefficients, three Horner multiplies, rounding) each handle one item a
//   cycle.
// Reset:
//   Point count returns to 16, the queue and pipeline empty; table contents
//   are undefined until written.
// Stall:
//   While m_axis_tvalid_o is high and m_axis_tready_i is low the back end
//   holds its stages and the output; the queue fills, then s_axis_tready_o drops.
// ----------------------------------------------------------------------------
module catmull_rom_closed_spline_eval import crs_pkg::*; (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  // Input stream
  input  logic                 s_axis_tvalid_i,
  output logic                 s_axis_tready_o,
  // tdata: point_index[3:0], point_x[19:4], point_y[35:20], param_t[51:36], zero pad
  input  logic [S_TDATA_W-1:0] s_axis_tdata_i,
  // tuser: action[1:0]
  input  logic [S_TUSER_W-1:0] s_axis_tuser_i,
  // Point count write
  input  logic                 cfg_valid_i,
  output logic                 cfg_ready_o,
  input  logic [CNT_W-1:0]     cfg_data_i,
  // Result stream
  output logic                 m_axis_tvalid_o,
  input  logic                 m_axis_tready_i,
  // tdata: out_x[23:0], out_y[47:24]
  output logic [M_TDATA_W-1:0] m_axis_tdata_o,
  // tuser: write_ack[0]
  output logic [M_TUSER_W-1:0] m_axis_tuser_o
);

  logic f_valid;
  logic f_ready;
  cmd_t f_cmd;
  logic q_valid;
  logic q_ready;
  cmd_t q_cmd;

  crs_front u_front (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_axis_tvalid_i),
    .s_axis_tready_o (s_axis_tready_o),
    .s_axis_tdata_i  (s_axis_tdata_i),
    .s_axis_tuser_i  (s_axis_tuser_i),
    .cfg_valid_i     (cfg_valid_i),
    .cfg_ready_o     (cfg_ready_o),
    .cfg_data_i      (cfg_data_i),
    .cmd_valid_o     (f_valid),
    .cmd_ready_i     (f_ready),
    .cmd_o           (f_cmd)
  );

  crs_fifo u_fifo (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (f_valid),
    .push_ready_o (f_ready),
    .push_cmd_i   (f_cmd),
    .pop_valid_o  (q_valid),
    .pop_ready_i  (q_ready),
    .pop_cmd_o    (q_cmd)
  );

  crs_back u_back (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cmd_valid_i     (q_valid),
    .cmd_ready_o     (q_ready),
    .cmd_i           (q_cmd),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_axis_tready_i),
    .m_axis_tdata_o  (m_axis_tdata_o),
    .m_axis_tuser_o  (m_axis_tuser_o)
  );

  // A command leaves the queue only while the back end can move
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (q_valid && q_ready) |-> (!m_axis_tvalid_o || m_axis_tready_i))
    else $error("command popped while the output is stalled");

  // Write acknowledges carry zero coordinates
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid_o && m_axis_tuser_o[0]) |-> (m_axis_tdata_o == '0))
    else $error("write acknowledge with nonzero data");

  // Neighbors of a segment never coincide with it on a loop of two or more
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (q_valid && (q_cmd.kind == ACT_POS || q_cmd.kind == ACT_GRAD)) |->
      (q_cmd.nbr[0] != q_cmd.nbr[1] && q_cmd.nbr[2] != q_cmd.nbr[1]))
    else $error("neighbor index wrap is wrong");

endmodule
